// ----- sv/hxt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxt_pkg
// Shared constants and types of the hextile tile decoder.
// ----------------------------------------------------------------------------
package hxt_pkg;

	localparam int TILE_SIZE  = 16;
	localparam int ROW_W      = TILE_SIZE * 8;
	localparam int CFG_IDX_W  = 8;

	// subencoding flag bits
	localparam int F_RAW = 0;
	localparam int F_BG  = 1;
	localparam int F_FG  = 2;
	localparam int F_ANY = 3;
	localparam int F_COL = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RECT_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_W = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_H = 8'd3;

	typedef enum logic [3:0] {
		ST_SUBENC,
		ST_RAW,
		ST_BG,
		ST_FG,
		ST_NSUB,
		ST_SCOL,
		ST_SXY,
		ST_SWH,
		ST_FILL,
		ST_PAINT,
		ST_EMIT_RD,
		ST_EMIT_LD
	} hxt_state_t;

	typedef struct packed {
		logic ld_flags;
		logic ld_bg;
		logic ld_fg;
		logic ld_nsub;
		logic ld_col;
		logic ld_xy;
		logic ld_wh;
		logic raw_start;
		logic raw_wr;
		logic fill_row;
		logic paint_row;
		logic emit_rd;
		logic emit_ld;
		logic tile_adv;
	} hxt_cmd_t;

	typedef struct packed {
		logic [4:0] flags;
		logic       empty;
		logic       raw_last;
		logic       fill_last;
		logic       paint_none;
		logic       paint_last;
		logic       sub_zero;
		logic       emit_last;
		logic       out_free;
	} hxt_stat_t;

endpackage

// ----- sv/hxt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxt_if
// Handshake channels of the hextile tile decoder: stream, rows, config.
// ----------------------------------------------------------------------------
interface hxt_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface hxt_row_if;
	logic        valid;
	logic        ready;
	logic [15:0] tile_left;
	logic [15:0] tile_top;
	logic [3:0]  row_index;
	logic [4:0]  row_width;
	logic [63:0] pixels_low;
	logic [63:0] pixels_high;
	logic        tile_done;
	logic        rect_done;
	modport source (output valid, output tile_left, output tile_top, output row_index,
		output row_width, output pixels_low, output pixels_high, output tile_done,
		output rect_done, input ready);
	modport sink (input valid, input tile_left, input tile_top, input row_index,
		input row_width, input pixels_low, input pixels_high, input tile_done,
		input rect_done, output ready);
endinterface

interface hxt_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/hextile_tile_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hextile_tile_decoder
// Hextile rectangle decoder for 8-bit pixels, one tile row per result.
// ----------------------------------------------------------------------------
// Usage:
//  cfg    : write rect_x (0), rect_y (1), rect_w (2), rect_h (3) while idle;
//           any of these writes re-arms the decoder for a new rectangle.
//  stream : one payload byte per transfer, be it a header, color, count,
//           subrect or raw byte.
//  rows   : one transfer per tile row, up to 16 pixels, with tile position.
// Sequence: a non-raw tile fills all 16 rows of its store after its header
//  and colors; each subrect paints one tile row per cycle, starting after its
//  wh byte. Emission reads the row-wide store one row at a time, through a
//  read state and then a load state per row. The stream is held off (ready low)
//  during fill, paint and emission.
// A stalled rows receiver holds the output register; emission waits on it,
//  and once the last row is loaded the stream is taken again.
// Reset clears the registers to a zero rectangle, whose bytes are dropped.
// The tile store is not cleared; every tile writes it before it is read.
// ----------------------------------------------------------------------------
module hextile_tile_decoder (
	input  logic clk,
	input  logic arst_n,
	hxt_stream_if.sink stream,
	hxt_row_if.source  rows,
	hxt_cfg_if.sink    cfg
);
	import hxt_pkg::*;

	hxt_cmd_t  cmd;
	hxt_stat_t stat;
	logic      cfg_we;
	logic      rearm;

	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid;
	assign rearm = cfg_we && (cfg.index == REG_RECT_X || cfg.index == REG_RECT_Y ||
		cfg.index == REG_RECT_W || cfg.index == REG_RECT_H);

	hxt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (stream.valid),
		.in_ready    (stream.ready),
		.stream_byte (stream.stream_byte),
		.rearm       (rearm),
		.stat        (stat),
		.cmd         (cmd)
	);

	hxt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.stream_byte (stream.stream_byte),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_ready   (rows.ready),
		.out_valid   (rows.valid),
		.tile_left   (rows.tile_left),
		.tile_top    (rows.tile_top),
		.row_index   (rows.row_index),
		.row_width   (rows.row_width),
		.pixels_low  (rows.pixels_low),
		.pixels_high (rows.pixels_high),
		.tile_done   (rows.tile_done),
		.rect_done   (rows.rect_done)
	);

endmodule

// ----- sv/hxt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxt_dp
// Datapath: rectangle registers, tile position, colors, row-wide tile store,
// subrect painter and output row register.
// ----------------------------------------------------------------------------
module hxt_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hxt_pkg::hxt_cmd_t       cmd,
	output hxt_pkg::hxt_stat_t      stat,
	input  logic [7:0]              stream_byte,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [15:0]             tile_left,
	output logic [15:0]             tile_top,
	output logic [3:0]              row_index,
	output logic [4:0]              row_width,
	output logic [63:0]             pixels_low,
	output logic [63:0]             pixels_high,
	output logic                    tile_done,
	output logic                    rect_done
);
	import hxt_pkg::*;

	logic [15:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;
	logic [15:0] tx_q, ty_q;
	logic [7:0]  bg_q, fg_q, col_q, xy_q, wh_q, nsub_q;
	logic [4:0]  flags_q;
	logic [3:0]  rr_q, rc_q, fr_q, pr_q, er_q;
	logic [ROW_W-1:0] mem [TILE_SIZE];
	logic [ROW_W-1:0] rd_q;

	logic        rearm;
	logic [15:0] rem_w, rem_h;
	logic [4:0]  tw, th;
	logic [16:0] nx, ny;
	logic        wrap_x, last_tile;
	logic [4:0]  end_c, end_r, pend;
	logic [7:0]  paint_col;
	logic        we;
	logic [3:0]  wa;
	logic [TILE_SIZE-1:0] wmask;
	logic [7:0]  wbyte;
	logic [ROW_W-1:0] masked;

	assign rearm = cfg_we && (cfg_index == REG_RECT_X || cfg_index == REG_RECT_Y ||
		cfg_index == REG_RECT_W || cfg_index == REG_RECT_H);

	assign rem_w = rect_w_q - tx_q;
	assign rem_h = rect_h_q - ty_q;
	assign tw = (rem_w > 16'(TILE_SIZE)) ? 5'(TILE_SIZE) : rem_w[4:0];
	assign th = (rem_h > 16'(TILE_SIZE)) ? 5'(TILE_SIZE) : rem_h[4:0];
	assign nx = {1'b0, tx_q} + 17'(TILE_SIZE);
	assign ny = {1'b0, ty_q} + 17'(TILE_SIZE);
	assign wrap_x = nx >= {1'b0, rect_w_q};
	assign last_tile = wrap_x && (ny >= {1'b0, rect_h_q});

	// inclusive subrect end; the row end is clipped to the tile
	assign end_c = {1'b0, xy_q[7:4]} + {1'b0, wh_q[7:4]};
	assign end_r = {1'b0, xy_q[3:0]} + {1'b0, wh_q[3:0]};
	assign pend = (end_r < th - 5'd1) ? end_r : th - 5'd1;
	assign paint_col = flags_q[F_COL] ? col_q : fg_q;

	always_comb begin
		stat.flags      = flags_q;
		stat.empty      = (rect_w_q == 16'd0) || (rect_h_q == 16'd0);
		stat.raw_last   = ({1'b0, rr_q} == th - 5'd1) && ({1'b0, rc_q} == tw - 5'd1);
		stat.fill_last  = fr_q == 4'(TILE_SIZE - 1);
		stat.paint_none = {1'b0, xy_q[3:0]} >= th;
		stat.paint_last = {1'b0, pr_q} >= pend;
		stat.sub_zero   = nsub_q == 8'd0;
		stat.emit_last  = {1'b0, er_q} == th - 5'd1;
		stat.out_free   = !out_valid || out_ready;
	end

	// one write port, byte enables
	always_comb begin
		we = 1'b0;
		wa = fr_q;
		wmask = '0;
		wbyte = bg_q;
		if (cmd.fill_row) begin
			we = 1'b1;
			wmask = '1;
		end else if (cmd.raw_wr) begin
			we = 1'b1;
			wa = rr_q;
			wbyte = stream_byte;
			wmask[rc_q] = 1'b1;
		end else if (cmd.paint_row) begin
			we = 1'b1;
			wa = pr_q;
			wbyte = paint_col;
			for (int c = 0; c < TILE_SIZE; c++) begin
				wmask[c] = (5'(c) >= {1'b0, xy_q[7:4]}) && (5'(c) <= end_c) && (5'(c) < tw);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			for (int c = 0; c < TILE_SIZE; c++) begin
				if (wmask[c]) mem[wa][c*8 +: 8] <= wbyte;
			end
		end
		if (cmd.emit_rd) rd_q <= mem[er_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q <= '0;
			rect_y_q <= '0;
			rect_w_q <= '0;
			rect_h_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			bg_q <= '0;
			fg_q <= '0;
			col_q <= '0;
			xy_q <= '0;
			wh_q <= '0;
			nsub_q <= '0;
			flags_q <= '0;
			rr_q <= '0;
			rc_q <= '0;
			fr_q <= '0;
			pr_q <= '0;
			er_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RECT_X: rect_x_q <= cfg_data;
					REG_RECT_Y: rect_y_q <= cfg_data;
					REG_RECT_W: rect_w_q <= cfg_data;
					REG_RECT_H: rect_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (rearm) begin
				tx_q <= '0;
				ty_q <= '0;
				bg_q <= '0;
				fg_q <= '0;
				er_q <= '0;
				fr_q <= '0;
			end else begin
				if (cmd.ld_flags) flags_q <= stream_byte[4:0];
				if (cmd.ld_bg) bg_q <= stream_byte;
				if (cmd.ld_fg) fg_q <= stream_byte;
				if (cmd.ld_nsub) nsub_q <= stream_byte;
				if (cmd.ld_col) col_q <= stream_byte;
				if (cmd.ld_xy) xy_q <= stream_byte;
				if (cmd.ld_wh) begin
					wh_q <= stream_byte;
					pr_q <= xy_q[3:0];
					nsub_q <= nsub_q - 8'd1;
				end
				if (cmd.paint_row) pr_q <= pr_q + 4'd1;
				if (cmd.fill_row) fr_q <= fr_q + 4'd1;
				if (cmd.raw_start) begin
					rr_q <= '0;
					rc_q <= '0;
				end else if (cmd.raw_wr) begin
					if ({1'b0, rc_q} == tw - 5'd1) begin
						rc_q <= '0;
						rr_q <= rr_q + 4'd1;
					end else begin
						rc_q <= rc_q + 4'd1;
					end
				end
				if (cmd.tile_adv) er_q <= '0;
				else if (cmd.emit_ld) er_q <= er_q + 4'd1;
				if (cmd.tile_adv) begin
					if (last_tile) begin
						tx_q <= '0;
						ty_q <= '0;
						bg_q <= '0;
						fg_q <= '0;
					end else if (wrap_x) begin
						tx_q <= '0;
						ty_q <= ny[15:0];
					end else begin
						tx_q <= nx[15:0];
					end
				end
			end
		end
	end

	// blank the bytes beyond the tile width
	always_comb begin
		for (int c = 0; c < TILE_SIZE; c++) begin
			masked[c*8 +: 8] = (5'(c) < tw) ? rd_q[c*8 +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			tile_left   <= rect_x_q + tx_q;
			tile_top    <= rect_y_q + ty_q;
			row_index   <= er_q;
			row_width   <= tw;
			pixels_low  <= masked[63:0];
			pixels_high <= masked[127:64];
			tile_done   <= stat.emit_last;
			rect_done   <= stat.emit_last && last_tile;
		end
	end

endmodule

// ----- sv/hxt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxt_ctrl
// Controller: parses the byte stream and sequences fill, paint and emit.
// ----------------------------------------------------------------------------
module hxt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         stream_byte,
	input  logic               rearm,
	input  hxt_pkg::hxt_stat_t stat,
	output hxt_pkg::hxt_cmd_t  cmd
);
	import hxt_pkg::*;

	hxt_state_t state_q, state_d;
	logic       go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_SUBENC;
		else if (rearm) state_q <= ST_SUBENC;
		else state_q <= state_d;
	end

	always_comb begin
		in_ready = (state_q == ST_SUBENC) || (state_q == ST_RAW) || (state_q == ST_BG) ||
			(state_q == ST_FG) || (state_q == ST_NSUB) || (state_q == ST_SCOL) ||
			(state_q == ST_SXY) || (state_q == ST_SWH);
		// bytes of an empty rectangle are taken and dropped
		go = in_valid && in_ready && !stat.empty;
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_SUBENC: if (go) begin
				cmd.ld_flags = 1'b1;
				if (stream_byte[F_RAW]) begin
					cmd.raw_start = 1'b1;
					state_d = ST_RAW;
				end else if (stream_byte[F_BG]) state_d = ST_BG;
				else if (stream_byte[F_FG]) state_d = ST_FG;
				else state_d = ST_FILL;
			end
			ST_RAW: if (go) begin
				cmd.raw_wr = 1'b1;
				if (stat.raw_last) state_d = ST_EMIT_RD;
			end
			ST_BG: if (go) begin
				cmd.ld_bg = 1'b1;
				state_d = stat.flags[F_FG] ? ST_FG : ST_FILL;
			end
			ST_FG: if (go) begin
				cmd.ld_fg = 1'b1;
				state_d = ST_FILL;
			end
			ST_NSUB: if (go) begin
				cmd.ld_nsub = 1'b1;
				if (stream_byte == 8'd0) state_d = ST_EMIT_RD;
				else state_d = stat.flags[F_COL] ? ST_SCOL : ST_SXY;
			end
			ST_SCOL: if (go) begin
				cmd.ld_col = 1'b1;
				state_d = ST_SXY;
			end
			ST_SXY: if (go) begin
				cmd.ld_xy = 1'b1;
				state_d = ST_SWH;
			end
			ST_SWH: if (go) begin
				cmd.ld_wh = 1'b1;
				state_d = ST_PAINT;
			end
			ST_FILL: begin
				cmd.fill_row = 1'b1;
				if (stat.fill_last) state_d = stat.flags[F_ANY] ? ST_NSUB : ST_EMIT_RD;
			end
			ST_PAINT: begin
				cmd.paint_row = !stat.paint_none;
				if (stat.paint_none || stat.paint_last) begin
					if (stat.sub_zero) state_d = ST_EMIT_RD;
					else state_d = stat.flags[F_COL] ? ST_SCOL : ST_SXY;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: if (stat.out_free) begin
				cmd.emit_ld = 1'b1;
				if (stat.emit_last) begin
					cmd.tile_adv = 1'b1;
					state_d = ST_SUBENC;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			default: state_d = ST_SUBENC;
		endcase
	end

endmodule

// ----- sv/hxt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxt_checker
// Port-level checks on the row channel of the hextile tile decoder.
// ----------------------------------------------------------------------------
module hxt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [3:0] row_index,
	input logic [4:0] row_width,
	input logic       tile_done,
	input logic       rect_done
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("row transfer dropped while stalled");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (row_width != 5'd0) && (row_width <= 5'd16))
		else $error("row width out of range");

	a_rect_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rect_done |-> tile_done)
		else $error("rectangle end not on tile end");

	a_row15: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (row_index == 4'd15) |-> tile_done)
		else $error("row 15 not last of tile");

endmodule

bind hextile_tile_decoder hxt_checker u_hxt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (rows.valid),
	.ready     (rows.ready),
	.row_index (rows.row_index),
	.row_width (rows.row_width),
	.tile_done (rows.tile_done),
	.rect_done (rows.rect_done)
);

// ----- dv/hextile_tile_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hextile_tile_decoder_test
// Feeds hextile rectangles one stream byte per transfer, with random gaps on
// the stream and random stalls on the rows channel, and compares every row
// transfer with rows predicted from the accepted bytes and register writes.
// ----------------------------------------------------------------------------
module hextile_tile_decoder_test;
	import hxt_pkg::*;

	localparam int SETTLE = 60;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_BYTES = 500;

	typedef enum {P_SUBENC, P_RAW, P_BG, P_FG, P_NSUB, P_SCOL, P_SXY, P_SWH} parse_t;
	typedef enum {J_BYTE, J_REG, J_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t kind;
		logic [7:0] idx;
		logic [15:0] val;
		logic calm;
	} job_t;

	typedef struct {
		logic [15:0] left;
		logic [15:0] top;
		logic [3:0] ri;
		logic [4:0] rwd;
		logic [63:0] lo;
		logic [63:0] hi;
		logic td;
		logic rd;
	} row_t;

	logic clk;
	logic arst_n;

	hxt_stream_if stream ();
	hxt_row_if rows ();
	hxt_cfg_if cfg ();

	hextile_tile_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream.sink),
		.rows(rows.source),
		.cfg(cfg.sink)
	);

	job_t pending_jobs[$];
	row_t expected_rows[$];

	// decoder image
	logic [15:0] rect_x, rect_y, rect_w, rect_h;
	parse_t phase;
	int tile_x, tile_y;
	logic [7:0] bg, fg, nsub, scol, sxy;
	logic [4:0] flags;
	int raw_cnt;
	logic [7:0] store [256];

	bit s_fire, c_fire, r_fire;
	int quiet;
	int idle_cycles;
	int gap;
	int stall;
	bit row_calm;
	int mismatches;
	int stream_bytes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int tile_width();
		int w;
		w = int'(rect_w) - tile_x;
		return (w > TILE_SIZE) ? TILE_SIZE : w;
	endfunction

	function automatic int tile_height();
		int h;
		h = int'(rect_h) - tile_y;
		return (h > TILE_SIZE) ? TILE_SIZE : h;
	endfunction

	task automatic rearm();
		phase = P_SUBENC;
		tile_x = 0;
		tile_y = 0;
		bg = '0;
		fg = '0;
		flags = '0;
		nsub = '0;
		scol = '0;
		sxy = '0;
		raw_cnt = 0;
	endtask

	task automatic emit_tile();
		int tw, th, nx, ny;
		bit last;
		row_t row;
		tw = tile_width();
		th = tile_height();
		last = 1'b0;
		nx = tile_x + TILE_SIZE;
		ny = tile_y;
		if (nx >= int'(rect_w)) begin
			nx = 0;
			ny = tile_y + TILE_SIZE;
			last = (ny >= int'(rect_h));
		end
		for (int r = 0; r < th; r++) begin
			row.lo = '0;
			row.hi = '0;
			for (int c = 0; c < tw; c++) begin
				if (c < 8)
					row.lo[8*c +: 8] = store[r*16 + c];
				else
					row.hi[8*(c-8) +: 8] = store[r*16 + c];
			end
			row.left = rect_x + tile_x[15:0];
			row.top = rect_y + tile_y[15:0];
			row.ri = r[3:0];
			row.rwd = tw[4:0];
			row.td = (r + 1 == th);
			row.rd = last && (r + 1 == th);
			expected_rows.push_back(row);
		end
		if (last) begin
			rearm();
		end else begin
			tile_x = nx;
			tile_y = ny;
			phase = P_SUBENC;
		end
	endtask

	task automatic fill_or_emit();
		for (int i = 0; i < 256; i++)
			store[i] = bg;
		if (flags[F_ANY])
			phase = P_NSUB;
		else
			emit_tile();
	endtask

	task automatic paint(input logic [7:0] wh);
		int tw, th, sx, sy, sw, sh;
		logic [7:0] color;
		tw = tile_width();
		th = tile_height();
		sx = int'(sxy[7:4]);
		sy = int'(sxy[3:0]);
		sw = int'(wh[7:4]) + 1;
		sh = int'(wh[3:0]) + 1;
		color = flags[F_COL] ? scol : fg;
		for (int r = sy; r < sy + sh && r < th; r++)
			for (int c = sx; c < sx + sw && c < tw; c++)
				store[r*16 + c] = color;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] v);
		case (idx)
			REG_RECT_X: rect_x = v;
			REG_RECT_Y: rect_y = v;
			REG_RECT_W: rect_w = v;
			REG_RECT_H: rect_h = v;
			default: return;
		endcase
		rearm();
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int tw;
		if (rect_w == 0 || rect_h == 0)
			return;
		case (phase)
			P_RAW: begin
				tw = tile_width();
				store[(raw_cnt / tw)*16 + raw_cnt % tw] = b;
				raw_cnt++;
				if (raw_cnt >= tw * tile_height())
					emit_tile();
			end
			P_BG: begin
				bg = b;
				if (flags[F_FG])
					phase = P_FG;
				else
					fill_or_emit();
			end
			P_FG: begin
				fg = b;
				fill_or_emit();
			end
			P_NSUB: begin
				nsub = b;
				if (b == 0)
					emit_tile();
				else
					phase = flags[F_COL] ? P_SCOL : P_SXY;
			end
			P_SCOL: begin
				scol = b;
				phase = P_SXY;
			end
			P_SXY: begin
				sxy = b;
				phase = P_SWH;
			end
			P_SWH: begin
				paint(b);
				nsub = nsub - 8'd1;
				if (nsub == 0)
					emit_tile();
				else
					phase = flags[F_COL] ? P_SCOL : P_SXY;
			end
			default: begin
				flags = b[4:0];
				if (flags[F_RAW]) begin
					raw_cnt = 0;
					phase = P_RAW;
				end else if (flags[F_BG]) begin
					phase = P_BG;
				end else if (flags[F_FG]) begin
					phase = P_FG;
				end else begin
					fill_or_emit();
				end
			end
		endcase
	endtask

	// ---------------- stimulus generation ----------------
	bit gen_calm;

	task automatic push_byte(input logic [7:0] b);
		job_t j;
		j.kind = J_BYTE;
		j.idx = '0;
		j.val = {8'h00, b};
		j.calm = gen_calm;
		pending_jobs.push_back(j);
		stream_bytes++;
	endtask

	task automatic push_reg(input logic [7:0] idx, input logic [15:0] v);
		job_t j;
		j.kind = J_REG;
		j.idx = idx;
		j.val = v;
		j.calm = gen_calm;
		pending_jobs.push_back(j);
	endtask

	task automatic push_drain();
		job_t j;
		j.kind = J_DRAIN;
		j.idx = '0;
		j.val = '0;
		j.calm = gen_calm;
		pending_jobs.push_back(j);
	endtask

	task automatic set_rect(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w, input logic [15:0] h);
		push_reg(REG_RECT_X, x);
		push_reg(REG_RECT_Y, y);
		push_reg(REG_RECT_W, w);
		push_reg(REG_RECT_H, h);
	endtask

	task automatic gen_tile(input int tw, input int th);
		logic [7:0] hdr;
		int n;
		hdr = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0) begin
			hdr[F_RAW] = 1'b1;
			push_byte(hdr);
			for (int i = 0; i < tw * th; i++)
				push_byte(8'($urandom_range(0, 255)));
			return;
		end
		hdr[F_RAW] = 1'b0;
		push_byte(hdr);
		if (hdr[F_BG])
			push_byte(8'($urandom_range(0, 255)));
		if (hdr[F_FG])
			push_byte(8'($urandom_range(0, 255)));
		if (hdr[F_ANY]) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
			push_byte(n[7:0]);
			for (int i = 0; i < n; i++) begin
				if (hdr[F_COL])
					push_byte(8'($urandom_range(0, 255)));
				push_byte(8'($urandom_range(0, 255)));
				push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic gen_rect(input logic [15:0] x, input logic [15:0] y,
			input int w, input int h);
		set_rect(x, y, w[15:0], h[15:0]);
		if (w == 0 || h == 0) begin
			for (int i = 0; i < 3; i++)
				push_byte(8'($urandom_range(0, 255)));
			return;
		end
		for (int ty = 0; ty < h; ty += TILE_SIZE)
			for (int tx = 0; tx < w; tx += TILE_SIZE)
				gen_tile((w - tx > TILE_SIZE) ? TILE_SIZE : w - tx,
					(h - ty > TILE_SIZE) ? TILE_SIZE : h - ty);
	endtask

	task automatic gen_directed();
		gen_calm = 1'b1;
		// empty rectangle, bytes dropped
		set_rect(16'h0000, 16'h0000, 16'h0000, 16'h0005);
		push_byte(8'h00);
		push_byte(8'hFF);
		// 1x1 at the far corner: raw with every other flag set
		set_rect(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
		push_byte(8'hFF);
		push_byte(8'hAB);
		// subrect starting outside the tile paints nothing
		set_rect(16'hFFF8, 16'h0010, 16'h0001, 16'h0001);
		push_byte(8'h1E);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h01);
		push_byte(8'h55);
		push_byte(8'hFF);
		push_byte(8'hFF);
		// 17x17: full tile, edge tiles, clipped subrect, zero count
		set_rect(16'h0100, 16'h0200, 16'd17, 16'd17);
		push_byte(8'h0A);
		push_byte(8'h12);
		push_byte(8'h02);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hEE);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h08);
		push_byte(8'h00);
		push_byte(8'hE4);
		push_byte(8'h77);
		push_drain();
		// widest and tallest rectangles, abandoned after a few tiles
		set_rect(16'h1234, 16'h4321, 16'hFFFF, 16'h0001);
		push_byte(8'h00);
		push_byte(8'h02);
		push_byte(8'h9C);
		set_rect(16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
		push_byte(8'h04);
		push_byte(8'h3C);
		push_byte(8'h01);
		push_byte(8'h5A);
		push_byte(8'h06);
	endtask

	task automatic gen_random();
		int start;
		int w, h;
		start = stream_bytes;
		while (stream_bytes - start < RANDOM_BYTES) begin
			gen_calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					w = 0;
					h = $urandom_range(0, 40);
					if ($urandom_range(0, 1)) begin
						w = h;
						h = 0;
					end
				end
				1: begin
					w = $urandom_range(1, 2);
					h = $urandom_range(1, 2);
				end
				default: begin
					w = $urandom_range(1, 40);
					h = $urandom_range(1, 36);
				end
			endcase
			gen_rect(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), w, h);
			// broken stream: a few stray bytes, cut off by the next rectangle
			if ($urandom_range(0, 7) == 0) begin
				push_byte(8'($urandom_range(0, 255)));
				push_byte(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 5) == 0)
				push_drain();
		end
	endtask

	// ---------------- driver ----------------
	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	always @(negedge clk) begin
		bit nsv, ncv, nr;
		logic [7:0] nb, ni;
		logic [15:0] nd;
		if (arst_n) begin
			nsv = stream.valid && !s_fire;
			ncv = cfg.valid && !c_fire;
			nb = stream.stream_byte;
			ni = cfg.index;
			nd = cfg.data;
			if (!nsv && !ncv) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_jobs.size() > 0) begin
					case (pending_jobs[0].kind)
						J_BYTE: begin
							nsv = 1'b1;
							nb = pending_jobs[0].val[7:0];
							gap = draw_wait(pending_jobs[0].calm);
							void'(pending_jobs.pop_front());
						end
						J_REG: begin
							if (expected_rows.size() == 0 && quiet >= SETTLE) begin
								ncv = 1'b1;
								ni = pending_jobs[0].idx;
								nd = pending_jobs[0].val;
								gap = draw_wait(pending_jobs[0].calm);
								void'(pending_jobs.pop_front());
							end
						end
						default: begin
							if (expected_rows.size() == 0 && quiet >= SETTLE)
								void'(pending_jobs.pop_front());
						end
					endcase
				end
			end
			if (r_fire) begin
				stall = draw_wait(row_calm);
				if (rows.tile_done)
					row_calm = ($urandom_range(0, 3) == 0);
			end
			if (stall > 0) begin
				stall--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			stream.valid <= nsv;
			stream.stream_byte <= nb;
			cfg.valid <= ncv;
			cfg.index <= ni;
			cfg.data <= nd;
			rows.ready <= nr;
		end
	end

	// ---------------- monitor and checker ----------------
	always @(posedge clk) begin
		row_t want;
		s_fire = arst_n && stream.valid && stream.ready;
		c_fire = arst_n && cfg.valid && cfg.ready;
		r_fire = arst_n && rows.valid && rows.ready;
		if (c_fire)
			write_reg(cfg.index, cfg.data);
		if (s_fire)
			decode_byte(stream.stream_byte);
		if (r_fire) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row transfer: left=%h top=%h row=%0d",
						rows.tile_left, rows.tile_top, rows.row_index);
			end else begin
				want = expected_rows.pop_front();
				if (rows.tile_left !== want.left || rows.tile_top !== want.top ||
						rows.row_index !== want.ri || rows.row_width !== want.rwd ||
						rows.pixels_low !== want.lo || rows.pixels_high !== want.hi ||
						rows.tile_done !== want.td || rows.rect_done !== want.rd) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("row mismatch exp: left=%h top=%h row=%0d w=%0d lo=%h hi=%h td=%b rd=%b",
							want.left, want.top, want.ri, want.rwd, want.lo, want.hi,
							want.td, want.rd);
						$display("             got: left=%h top=%h row=%0d w=%0d lo=%h hi=%h td=%b rd=%b",
							rows.tile_left, rows.tile_top, rows.row_index, rows.row_width,
							rows.pixels_low, rows.pixels_high, rows.tile_done,
							rows.rect_done);
					end
				end
			end
		end
		if (expected_rows.size() != 0 || s_fire || c_fire)
			quiet = 0;
		else if (quiet < SETTLE)
			quiet++;
		if (s_fire || c_fire || r_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("hextile_tile_decoder_test failed");
			$finish;
		end
	end

	initial begin
		stream.valid = 1'b0;
		stream.stream_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		rows.ready = 1'b0;
		arst_n = 1'b0;
		s_fire = 1'b0;
		c_fire = 1'b0;
		r_fire = 1'b0;
		quiet = 0;
		idle_cycles = 0;
		gap = 0;
		stall = 0;
		row_calm = 1'b0;
		mismatches = 0;
		stream_bytes = 0;
		rect_x = '0;
		rect_y = '0;
		rect_w = '0;
		rect_h = '0;
		for (int i = 0; i < 256; i++)
			store[i] = '0;
		rearm();
		gen_directed();
		gen_random();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_jobs.size() != 0 || stream.valid || cfg.valid ||
				expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (expected_rows.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("hextile_tile_decoder_test passed");
		else
			$display("hextile_tile_decoder_test failed");
		$finish;
	end

endmodule
